>>> hw/rtl/bes_pkg.sv
// shared types, constants and codes for the block extent set engine
package bes_pkg;

  // default table depth and fixed field widths
  localparam int MAX_EXTENTS_DEF = 32;
  localparam int BLOCK_W         = 32;
  localparam int LEN_W           = 33;
  localparam int TOTAL_W         = 33;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_W           = $clog2(MAX_RESULTS);

  // the hole block can never be covered
  localparam logic [BLOCK_W-1:0] SPARSE_HOLE = '1;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_TAKE = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EXCEED  = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MPRIME,
    S_MERGE,
    S_BPRIME,
    S_BUILD,
    S_BUILD2,
    S_TAIL,
    S_COMMIT,
    S_TPRIME,
    S_TAKE,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BLOCK_W-1:0] first_block;
    logic [BLOCK_W-1:0] block_span;
    logic [LEN_W-1:0]   request_count;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total_after;
    logic [BLOCK_W-1:0] out_start;
    logic [LEN_W-1:0]   out_length;
    logic               last_of_run;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rewind;
    logic advance;
    logic merge_step;
    logic wr_first;
    logic wr_second;
    logic wr_tail;
    logic set_full;
    logic commit;
    logic report;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_op;
    logic [1:0] op;
    logic       immediate;
    logic       at_end;
    logic       any_write;
    logic       two_writes;
    logic       table_full;
    logic       take_last;
    logic       need_tail;
  } stat_t;

endpackage

>>> hw/rtl/block_extent_set_engine.sv
// top level of the block extent set engine
// Keeps a sorted table of disjoint block extents and their block total.
// An operation is taken when start is high and busy is low; busy stays high
// until the operation's last result is loaded, and each result shows on
// result for one cycle with result_valid high; the receiver cannot stall it,
// and last_of_run marks the final one. The table lives in one ram with a
// single read port, in two banks: each add or subtract rebuilds the table
// into the idle bank and swaps banks on success, so a full table or bad
// input leaves it untouched. The scan reads one entry per cycle, except that
// an entry which writes two rows (a split extent, or the new extent landing
// ahead of a kept one) holds it for a second write. An add runs a merge scan
// and then a rebuild scan, a subtract only the rebuild scan; a take holds
// busy while it emits its extents, and ignored or refused inputs go straight
// to the final result. A full table ends the rebuild scan early. The final
// result shows in the first cycle after busy falls.
module block_extent_set_engine #(
  parameter int MAX_EXTENTS = bes_pkg::MAX_EXTENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bes_pkg::req_t request,
  output bes_pkg::rsp_t result,
  output logic          result_valid
);
  import bes_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bes_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  bes_dp #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (request),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

`ifndef SYNTHESIS
  // an accepted transfer always raises busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not start an operation");

  // finishing an operation always delivers its final result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && result.last_of_run)
    else $error("operation ended without a final result");

  // a result that is not the last one comes while the operation runs
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_of_run |-> busy)
    else $error("intermediate result after operation end");
`endif

endmodule

>>> hw/rtl/bes_ram.sv
// generic single write port ram with registered read
module bes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bes_ctrl.sv
// sequencer for the extent table scans
module bes_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bes_pkg::stat_t stat,
  output bes_pkg::cmd_t  cmd,
  output logic           busy
);
  import bes_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.immediate) begin
            state_next = S_REPORT;
          end else begin
            unique case (stat.req_op)
              OP_ADD:  state_next = S_MPRIME;
              OP_SUB:  state_next = S_BPRIME;
              default: state_next = S_TPRIME;
            endcase
          end
        end
      end
      S_MPRIME: state_next = S_MERGE;
      S_MERGE: begin
        if (stat.at_end) begin
          state_next = S_BPRIME;
        end
      end
      S_BPRIME: state_next = S_BUILD;
      S_BUILD: begin
        if (stat.at_end) begin
          state_next = (stat.op == OP_ADD) ? S_TAIL : S_COMMIT;
        end else if (stat.any_write && stat.table_full) begin
          state_next = S_REPORT;
        end else if (stat.two_writes) begin
          state_next = S_BUILD2;
        end
      end
      S_BUILD2: begin
        state_next = stat.table_full ? S_REPORT : S_BUILD;
      end
      S_TAIL: begin
        state_next = (stat.need_tail && stat.table_full) ? S_REPORT : S_COMMIT;
      end
      S_COMMIT: state_next = S_REPORT;
      S_TPRIME: state_next = S_TAKE;
      S_TAKE: begin
        if (stat.take_last) begin
          state_next = S_IDLE;
        end
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_MERGE: begin
        if (stat.at_end) begin
          cmd.rewind = 1'b1;
        end else begin
          cmd.merge_step = 1'b1;
          cmd.advance    = 1'b1;
        end
      end
      S_BUILD: begin
        if (!stat.at_end) begin
          if (stat.any_write && stat.table_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.wr_first = 1'b1;
            cmd.advance  = !stat.two_writes;
          end
        end
      end
      S_BUILD2: begin
        if (stat.table_full) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.wr_second = 1'b1;
          cmd.advance   = 1'b1;
        end
      end
      S_TAIL: begin
        if (stat.need_tail) begin
          if (stat.table_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.wr_tail = 1'b1;
          end
        end
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_TAKE: begin
        cmd.emit    = 1'b1;
        cmd.advance = 1'b1;
      end
      S_REPORT: cmd.report = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/bes_dp.sv
// extent table datapath: double-banked table, merge and split logic, results
module bes_dp #(
  parameter int MAX_EXTENTS = bes_pkg::MAX_EXTENTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bes_pkg::req_t  req,
  input  bes_pkg::cmd_t  cmd,
  output bes_pkg::stat_t stat,
  output bes_pkg::rsp_t  result,
  output logic           result_valid
);
  import bes_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int AW = IW + 1;
  localparam int EW = BLOCK_W + LEN_W;
  localparam int XW = BLOCK_W + 2;

  // latched request
  logic [1:0]         op;
  logic [BLOCK_W-1:0] s_reg;
  logic [BLOCK_W-1:0] len_reg;
  logic [LEN_W-1:0]   cnt;

  // scan state
  logic [BLOCK_W-1:0] ns;
  logic [XW-1:0]      ne;
  logic [TOTAL_W-1:0] removed;
  logic [TOTAL_W-1:0] got;
  logic               placed;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      n;
  logic [RES_W-1:0]   k;
  logic [1:0]         status;

  // table state
  logic               bank;
  logic [CW-1:0]      count;
  logic [TOTAL_W-1:0] total;

  // ram signals
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [EW-1:0]      wdata;
  logic [EW-1:0]      rdata;
  logic [IW-1:0]      ridx;

  bes_ram #(
    .WIDTH(EW),
    .DEPTH(2 * MAX_EXTENTS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // entry under the scan pointer
  logic [BLOCK_W-1:0] a;
  logic [LEN_W-1:0]   l;
  logic [XW-1:0]      ae;
  assign a  = rdata[LEN_W +: BLOCK_W];
  assign l  = rdata[LEN_W-1:0];
  assign ae = {2'b00, a} + {1'b0, l};

  // immediate outcomes straight from the request
  logic               req_ignored;
  logic               req_exceed;
  logic [LEN_W-1:0]   req_end;
  logic [XW-1:0]      req_ne;
  always_comb begin
    req_ignored = (req.operation == OP_BAD)
               || (req.operation == OP_TAKE && req.request_count == '0)
               || ((req.operation == OP_ADD || req.operation == OP_SUB)
                   && (req.first_block == SPARSE_HOLE || req.block_span == '0));
    req_exceed  = (req.operation == OP_TAKE) && (req.request_count != '0)
               && (req.request_count > total);
    req_end     = {1'b0, req.first_block} + {1'b0, req.block_span};
    req_ne      = (req_end > {1'b0, SPARSE_HOLE}) ? {2'b00, SPARSE_HOLE}
                                                   : {1'b0, req_end};
  end

  // merge pass: grow the new extent over touching entries
  logic touch;
  assign touch = (a == ns) || ((a < ns) ? (ae >= {2'b00, ns}) : (ne >= {2'b00, a}));

  // build pass: entries written to the other bank
  logic [LEN_W-1:0]   mlen;
  logic [XW-1:0]      se;
  logic               swallowed;
  logic               put_m;
  logic               hit;
  logic               left;
  logic               right;
  logic [LEN_W-1:0]   left_len;
  logic [LEN_W-1:0]   right_len;
  logic [1:0]         nw;
  logic [EW-1:0]      item0;
  logic [EW-1:0]      item1;
  always_comb begin
    mlen      = LEN_W'(ne - {2'b00, ns});
    se        = {2'b00, s_reg} + {2'b00, len_reg};
    swallowed = (ae >= {2'b00, ns}) && ({2'b00, a} <= ne);
    put_m     = !placed && (a > ns);
    hit       = (a == s_reg) || ((a < s_reg) ? (ae > {2'b00, s_reg}) : (se > {2'b00, a}));
    left      = s_reg > a;
    right     = ae > se;
    left_len  = {1'b0, s_reg} - {1'b0, a};
    right_len = LEN_W'(ae - se);
    nw        = 2'd0;
    item0     = rdata;
    item1     = rdata;
    if (op == OP_ADD) begin
      if (!swallowed) begin
        if (put_m) begin
          nw    = 2'd2;
          item0 = {ns, mlen};
        end else begin
          nw    = 2'd1;
        end
      end
    end else if (!hit) begin
      nw = 2'd1;
    end else begin
      if (left && right) begin
        nw    = 2'd2;
        item0 = {a, left_len};
        item1 = {se[BLOCK_W-1:0], right_len};
      end else if (left) begin
        nw    = 2'd1;
        item0 = {a, left_len};
      end else if (right) begin
        nw    = 2'd1;
        item0 = {se[BLOCK_W-1:0], right_len};
      end
    end
  end

  // take: trim the entry to what is still needed
  logic [LEN_W-1:0] need;
  logic             done;
  logic [LEN_W-1:0] elen;
  logic             take_last;
  always_comb begin
    need      = cnt - got;
    done      = l >= need;
    elen      = done ? need : l;
    take_last = done || (k == RES_W'(MAX_RESULTS - 1)) || ((ptr + CW'(1)) == count);
  end

  // ram ports
  always_comb begin
    ridx  = cmd.advance ? IW'(ptr + CW'(1)) : ptr[IW-1:0];
    raddr = {bank, ridx};
    waddr = {~bank, n[IW-1:0]};
    we    = (cmd.wr_first && nw != 2'd0) || cmd.wr_second || cmd.wr_tail;
    if (cmd.wr_second) begin
      wdata = item1;
    end else if (cmd.wr_tail) begin
      wdata = {ns, mlen};
    end else begin
      wdata = item0;
    end
  end

  // status to the controller
  always_comb begin
    stat.req_op     = req.operation;
    stat.op         = op;
    stat.immediate  = req_ignored || req_exceed;
    stat.at_end     = (ptr == count);
    stat.any_write  = (nw != 2'd0);
    stat.two_writes = (nw == 2'd2);
    stat.table_full = (n == CW'(MAX_EXTENTS));
    stat.take_last  = take_last;
    stat.need_tail  = !placed;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bank         <= 1'b0;
      count        <= '0;
      total        <= '0;
      ptr          <= '0;
      n            <= '0;
      k            <= '0;
      placed       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.report || cmd.emit;
      if (cmd.load || cmd.rewind) begin
        ptr <= '0;
      end else if (cmd.advance) begin
        ptr <= ptr + CW'(1);
      end
      if (cmd.load) begin
        n      <= '0;
        k      <= '0;
        placed <= 1'b0;
      end else begin
        if (we) begin
          n <= n + CW'(1);
        end
        if (cmd.wr_first && op == OP_ADD && !swallowed && put_m) begin
          placed <= 1'b1;
        end
        if (cmd.emit) begin
          k <= k + RES_W'(1);
        end
      end
      if (cmd.commit) begin
        bank  <= ~bank;
        count <= n;
        if (op == OP_ADD) begin
          total <= total - removed + mlen;
        end else begin
          total <= total - removed;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= req.operation;
      s_reg   <= req.first_block;
      len_reg <= req.block_span;
      cnt     <= req.request_count;
      ns      <= req.first_block;
      ne      <= req_ne;
      removed <= '0;
      got     <= '0;
      if (req_ignored) begin
        status <= STAT_IGNORED;
      end else if (req_exceed) begin
        status <= STAT_EXCEED;
      end else begin
        status <= STAT_OK;
      end
    end else begin
      if (cmd.set_full) begin
        status <= STAT_FULL;
      end
      if (cmd.merge_step && touch) begin
        removed <= removed + l;
        if (a < ns) begin
          ns <= a;
        end
        if (ae > ne) begin
          ne <= ae;
        end
      end
      if (cmd.wr_first && op == OP_SUB && hit) begin
        removed <= removed + l - (left ? left_len : '0) - (right ? right_len : '0);
      end
      if (cmd.emit) begin
        got <= got + elen;
      end
    end
    if (cmd.report) begin
      result <= {status, total, {BLOCK_W{1'b0}}, {LEN_W{1'b0}}, 1'b1};
    end else if (cmd.emit) begin
      result <= {STAT_OK, total, a, elen, take_last};
    end
  end

endmodule

>>> tb/tb_block_extent_set_engine.sv
// testbench for the block extent set engine: directed table plus random operations
module tb_block_extent_set_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import bes_pkg::*;

  localparam int NEXT       = MAX_EXTENTS_DEF;
  localparam int WATCH_LIM  = 20000;
  localparam int N_RANDOM   = 373;
  localparam logic [32:0] HOLE33 = {1'b0, SPARSE_HOLE};

  typedef struct {
    op_t         op;
    logic [31:0] sblk;
    logic [31:0] nblk;
    logic [32:0] cnt;
    bit          has_exp;
    status_t     exp_status;
    logic [32:0] exp_total;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  rsp_t result;
  logic result_valid;

  // model copy of the extent table
  logic [31:0] ext_start[NEXT];
  logic [32:0] ext_len[NEXT];
  int          ext_cnt;
  logic [32:0] blk_total;

  rsp_t        pending_rsp[$];
  int          fail_cnt = 0;
  int          idle_cycles = 0;
  int          idle_pct = 0;

  block_extent_set_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .result(result), .result_valid(result_valid)
  );

  always #5 clk = ~clk;

  // add an extent, merging neighbors; returns status
  function automatic status_t set_add(logic [32:0] s, logic [32:0] len);
    logic [32:0] ns, ne, removed, a, ae;
    logic [31:0] ts[$];
    logic [32:0] tl[$];
    bit placed, touch;
    ns = s; ne = s + len; removed = '0; placed = 0;
    if (ne > HOLE33) ne = HOLE33;
    for (int i = 0; i < ext_cnt; i++) begin
      a = {1'b0, ext_start[i]}; ae = a + ext_len[i];
      touch = (a == ns) || ((a < ns) ? (ae >= ns) : (ne >= a));
      if (touch) begin
        removed += ext_len[i];
        if (a < ns) ns = a;
        if (ae > ne) ne = ae;
      end
    end
    for (int i = 0; i < ext_cnt; i++) begin
      a = {1'b0, ext_start[i]}; ae = a + ext_len[i];
      if (ae >= ns && a <= ne) continue;
      if (!placed && a > ns) begin
        if (ts.size() >= NEXT) return STAT_FULL;
        ts = {ts, ns[31:0]}; tl = {tl, ne - ns}; placed = 1;
      end
      if (ts.size() >= NEXT) return STAT_FULL;
      ts = {ts, a[31:0]}; tl = {tl, ext_len[i]};
    end
    if (!placed) begin
      if (ts.size() >= NEXT) return STAT_FULL;
      ts = {ts, ns[31:0]}; tl = {tl, ne - ns};
    end
    ext_cnt = ts.size();
    for (int i = 0; i < ext_cnt; i++) begin
      ext_start[i] = ts[i]; ext_len[i] = tl[i];
    end
    blk_total = blk_total - removed + (ne - ns);
    return STAT_OK;
  endfunction

  // remove a range, possibly splitting one extent
  function automatic status_t set_subtract(logic [32:0] s, logic [32:0] len);
    logic [32:0] se, removed, a, al, ae;
    logic [31:0] ts[$];
    logic [32:0] tl[$];
    bit hit;
    se = s + len; removed = '0;
    for (int i = 0; i < ext_cnt; i++) begin
      a = {1'b0, ext_start[i]}; al = ext_len[i]; ae = a + al;
      hit = (a == s) || ((a < s) ? (ae > s) : (se > a));
      if (!hit) begin
        if (ts.size() >= NEXT) return STAT_FULL;
        ts = {ts, a[31:0]}; tl = {tl, al};
        continue;
      end
      removed += al;
      if (s > a) begin
        if (ts.size() >= NEXT) return STAT_FULL;
        ts = {ts, a[31:0]}; tl = {tl, s - a}; removed -= s - a;
      end
      if (ae > se) begin
        if (ts.size() >= NEXT) return STAT_FULL;
        ts = {ts, se[31:0]}; tl = {tl, ae - se}; removed -= ae - se;
      end
    end
    ext_cnt = ts.size();
    for (int i = 0; i < ext_cnt; i++) begin
      ext_start[i] = ts[i]; ext_len[i] = tl[i];
    end
    blk_total -= removed;
    return STAT_OK;
  endfunction

  function automatic rsp_t mk_rsp(status_t st, logic [31:0] s, logic [32:0] l, bit last);
    rsp_t r;
    r.status = st; r.total_after = blk_total; r.out_start = s;
    r.out_length = l; r.last_of_run = last;
    return r;
  endfunction

  // work out the results of one operation and queue them
  function automatic void predict_extents(op_t op, logic [31:0] s, logic [31:0] n,
                                          logic [32:0] cnt);
    status_t st;
    logic [32:0] got, need, len;
    int k;
    bit done;
    if (op == OP_TAKE) begin
      if (cnt == 0) begin
        pending_rsp = {pending_rsp, mk_rsp(STAT_IGNORED, '0, '0, 1'b1)}; return;
      end
      if (cnt > blk_total) begin
        pending_rsp = {pending_rsp, mk_rsp(STAT_EXCEED, '0, '0, 1'b1)}; return;
      end
      got = '0; k = 0;
      for (int i = 0; i < ext_cnt && k < MAX_RESULTS; i++) begin
        need = cnt - got; len = ext_len[i];
        done = (len >= need);
        if (done) len = need;
        got += len;
        pending_rsp = {pending_rsp, mk_rsp(STAT_OK, ext_start[i], len,
                       done || k == MAX_RESULTS - 1 || i + 1 == ext_cnt)};
        k++;
        if (done) break;
      end
      if (k == 0) pending_rsp = {pending_rsp, mk_rsp(STAT_OK, '0, '0, 1'b1)};
      return;
    end
    if (op == OP_BAD || s == SPARSE_HOLE || n == 0) begin
      pending_rsp = {pending_rsp, mk_rsp(STAT_IGNORED, '0, '0, 1'b1)}; return;
    end
    st = (op == OP_ADD) ? set_add({1'b0, s}, {1'b0, n}) : set_subtract({1'b0, s}, {1'b0, n});
    pending_rsp = {pending_rsp, mk_rsp(st, '0, '0, 1'b1)};
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result %p", result);
        fail_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); fail_cnt++;
        end
        if (result.total_after !== e.total_after) begin
          $error("total_after exp %0d got %0d", e.total_after, result.total_after);
          fail_cnt++;
        end
        if (result.out_start !== e.out_start) begin
          $error("out_start exp %0h got %0h", e.out_start, result.out_start); fail_cnt++;
        end
        if (result.out_length !== e.out_length) begin
          $error("out_length exp %0d got %0d", e.out_length, result.out_length);
          fail_cnt++;
        end
        if (result.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, result.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIM) begin
      $display("FAIL");
      $finish;
    end
  end

  // issue one operation, wait for its transfer, then drop start
  task automatic send_op(op_t op, logic [31:0] s, logic [31:0] n, logic [32:0] cnt);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    request <= '{operation: op, first_block: s, block_span: n, request_count: cnt};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_extents(op, s, n, cnt);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // random operation: mostly small well-formed extents in a narrow window
  task automatic send_random();
    int pick;
    logic [31:0] s, n;
    logic [32:0] c;
    op_t op;
    pick = $urandom_range(99);
    s = $urandom_range(600); n = $urandom_range(1, 40);
    c = 33'($urandom_range(0, 80));
    if (pick < 45) op = OP_ADD;
    else if (pick < 75) op = OP_SUB;
    else if (pick < 92) op = OP_TAKE;
    else begin
      op = op_t'($urandom_range(3));
      s = $urandom(); n = $urandom();
      c = {1'($urandom_range(1)), 32'($urandom())};
      if ($urandom_range(3) == 0) s = SPARSE_HOLE;
      if ($urandom_range(3) == 0) n = '0;
    end
    if (op == OP_TAKE && $urandom_range(4) == 0) c = blk_total - 33'($urandom_range(2));
    send_op(op, s, n, c);
  endtask

  stim_row_t dir_rows[$];
  int step;

  initial begin
    // directed rows; expected values only where obvious
    dir_rows = '{
      '{OP_TAKE, 0, 0, 1, 1, STAT_EXCEED, 0},
      '{OP_TAKE, 0, 0, 0, 1, STAT_IGNORED, 0},
      '{OP_ADD, SPARSE_HOLE, 5, 0, 1, STAT_IGNORED, 0},
      '{OP_ADD, 10, 0, 0, 1, STAT_IGNORED, 0},
      '{OP_BAD, 10, 5, 5, 1, STAT_IGNORED, 0},
      '{OP_SUB, 0, 5, 0, 1, STAT_OK, 0},
      '{OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 1, STAT_OK, 33'd15},
      '{OP_ADD, 0, 32'hFFFF_FFFF, 0, 1, STAT_OK, HOLE33},
      '{OP_TAKE, 0, 0, HOLE33, 0, STAT_OK, 0},
      '{OP_TAKE, 0, 0, 33'h1_FFFF_FFFF, 1, STAT_EXCEED, HOLE33},
      '{OP_SUB, 0, 32'hFFFF_FFFF, 0, 0, STAT_OK, 0},
      '{OP_SUB, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, STAT_OK, 0},
      '{OP_SUB, 100, 32'hFFFF_FFFF, 0, 0, STAT_OK, 0},
      '{OP_SUB, 50, 10, 0, 0, STAT_OK, 0},
      '{OP_ADD, 40, 30, 0, 0, STAT_OK, 0},
      '{OP_ADD, 20, 20, 0, 0, STAT_OK, 0},
      '{OP_TAKE, 0, 0, 33'h1_0000_0000, 0, STAT_OK, 0},
      '{OP_TAKE, 0, 0, 150, 0, STAT_OK, 0},
      '{OP_SUB, 0, 32'hFFFF_FFFF, 0, 0, STAT_OK, 0}
    };
    ext_cnt = 0; blk_total = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].sblk, dir_rows[i].nblk, dir_rows[i].cnt);
      if (dir_rows[i].has_exp &&
          (pending_rsp[$].status !== dir_rows[i].exp_status ||
           pending_rsp[$].total_after !== dir_rows[i].exp_total)) begin
        $error("directed row %0d: table expects status %0d total %0d", i,
               dir_rows[i].exp_status, dir_rows[i].exp_total);
        fail_cnt++;
      end
    end
    // fill the table to overflow with spaced one-block extents, then take it all
    for (int i = 0; i <= NEXT; i++) send_op(OP_ADD, 32'(1000 + 4 * i), 1, 0);
    send_op(OP_SUB, 1001, 1, 0);
    send_op(OP_SUB, 1000, 1, 0);
    send_op(OP_ADD, 1000, 2, 0);
    send_op(OP_TAKE, 0, 0, blk_total);
    drain_results();
    send_op(OP_SUB, 0, 32'hFFFF_FFFF, 0);
    // random phases with different sender idling
    for (step = 0; step < N_RANDOM; step++) begin
      case (step * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 66;
        2: idle_pct = 38;
        default: idle_pct = (step % 40 < 20) ? 0 : 66;
      endcase
      if (step % 100 == 99) drain_results();
      send_random();
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/bes_pkg.sv
hw/rtl/bes_ram.sv
hw/rtl/bes_ctrl.sv
hw/rtl/bes_dp.sv
hw/rtl/block_extent_set_engine.sv
tb/tb_block_extent_set_engine.sv
